@@ design/cbss_pkg.sv @@
`default_nettype none

package cbss_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_HASH,
      MODE_WORD,
      MODE_LINE_C,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_STRING,
      MODE_STRING_Q
   } mode_type;

   typedef logic [2:0] outcome_type;

   localparam outcome_type OUT_SKIP    = 3'd0;
   localparam outcome_type OUT_ELSE    = 3'd1;
   localparam outcome_type OUT_ELIF    = 3'd2;
   localparam outcome_type OUT_ENDIF   = 3'd3;
   localparam outcome_type OUT_EOF     = 3'd4;
   localparam outcome_type OUT_EOF_STR = 3'd5;

   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_E       = 8'h65;

   // letters after "#e", first letter in the lowest byte
   localparam logic [31:0] WORD_LSE  = 32'h0065_736c;
   localparam logic [31:0] WORD_LIF  = 32'h0066_696c;
   localparam logic [31:0] WORD_NDIF = 32'h6669_646e;

   typedef struct packed {
      logic       step;
      logic [7:0] char_code;
      logic       end_of_input;
   } step_type;

endpackage

`default_nettype wire

@@ design/cbss_core.sv @@
`default_nettype none

module cbss_core #(
   parameter int WORD_MAX = 6
) (
   input  wire                  clock,
   input  wire                  reset,
   input  cbss_pkg::step_type   step_in,
   output cbss_pkg::outcome_type outcome
);
   import cbss_pkg::*;

   localparam int CountW = $clog2(WORD_MAX - 1);

   mode_type            mode_ff, mode_in;
   logic                line_start_ff, line_start_in;
   logic                slash_ff, slash_in;
   logic [3:0][7:0]     letters_ff, letters_in;
   logic [CountW-1:0]   count_ff, count_in;

   logic                run_normal;
   logic                is_letter;
   logic [CountW+1:0]   count_plus2;
   outcome_type         judged;
   outcome_type         res;
   logic [7:0]          c;
   logic                eof;

   always_comb begin
      c = step_in.char_code;
      eof = step_in.end_of_input;
      is_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
      count_plus2 = {2'b00, count_ff} + (CountW + 2)'(2);

      judged = OUT_SKIP;
      if (count_ff == CountW'(3) && letters_ff == WORD_LSE) begin
         judged = OUT_ELSE;
      end else if (count_ff == CountW'(3) && letters_ff == WORD_LIF) begin
         judged = OUT_ELIF;
      end else if (count_ff == CountW'(4) && letters_ff == WORD_NDIF) begin
         judged = OUT_ENDIF;
      end

      mode_in = mode_ff;
      line_start_in = line_start_ff;
      slash_in = slash_ff;
      letters_in = letters_ff;
      count_in = count_ff;
      res = OUT_SKIP;
      run_normal = 1'b0;

      unique case (mode_ff)
         MODE_HASH: begin
            mode_in = MODE_NORMAL;
            if (!eof && c == CH_E) begin
               mode_in = MODE_WORD;
               letters_in = '0;
               count_in = '0;
            end else begin
               run_normal = 1'b1;
            end
         end
         MODE_WORD: begin
            if (!eof && is_letter) begin
               if (count_plus2 >= (CountW + 2)'(WORD_MAX)) begin
                  mode_in = MODE_NORMAL;
                  letters_in = '0;
                  count_in = '0;
               end else begin
                  if (count_ff < CountW'(4)) begin
                     letters_in[count_ff[1:0]] = c;
                  end
                  count_in = count_ff + CountW'(1);
               end
            end else begin
               res = judged;
               mode_in = MODE_NORMAL;
               letters_in = '0;
               count_in = '0;
               run_normal = (judged == OUT_SKIP);
            end
         end
         MODE_LINE_C: begin
            if (eof) begin
               res = OUT_EOF;
            end else if (c == CH_NEWLINE) begin
               run_normal = 1'b1;
            end
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (eof) begin
               res = OUT_EOF;
            end else if (c == CH_SLASH && mode_ff == MODE_BLOCK_STAR) begin
               mode_in = MODE_NORMAL;
               slash_in = 1'b0;
            end else begin
               mode_in = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
         end
         MODE_STRING: begin
            if (eof) begin
               res = OUT_EOF_STR;
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_STRING_Q;
            end
         end
         MODE_STRING_Q: begin
            if (!eof && c == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else begin
               run_normal = 1'b1;
            end
         end
         default: begin
            run_normal = 1'b1;
         end
      endcase

      // ordinary text handling
      if (run_normal) begin
         mode_in = MODE_NORMAL;
         if (eof) begin
            res = OUT_EOF;
         end else begin
            case (c)
               CH_NEWLINE: begin
                  line_start_in = 1'b1;
                  slash_in = 1'b0;
               end
               CH_HASH: begin
                  if (line_start_ff) begin
                     mode_in = MODE_HASH;
                  end
                  line_start_in = 1'b0;
                  slash_in = 1'b0;
               end
               CH_SLASH: begin
                  if (slash_ff) begin
                     mode_in = MODE_LINE_C;
                     slash_in = 1'b0;
                  end else begin
                     slash_in = 1'b1;
                  end
               end
               CH_STAR: begin
                  if (slash_ff) begin
                     mode_in = MODE_BLOCK;
                     slash_in = 1'b0;
                  end
               end
               CH_SPACE, CH_TAB: begin
                  slash_in = 1'b0;
               end
               CH_QUOTE: begin
                  mode_in = MODE_STRING;
               end
               default: begin
                  slash_in = 1'b0;
                  line_start_in = 1'b0;
               end
            endcase
         end
      end

      // rearm after any report
      if (res != OUT_SKIP) begin
         mode_in = MODE_NORMAL;
         line_start_in = 1'b1;
         slash_in = 1'b0;
         letters_in = '0;
         count_in = '0;
      end

      outcome = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         line_start_ff <= 1'b1;
         slash_ff <= 1'b0;
         letters_ff <= '0;
         count_ff <= '0;
      end else if (step_in.step) begin
         mode_ff <= mode_in;
         line_start_ff <= line_start_in;
         slash_ff <= slash_in;
         letters_ff <= letters_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/conditional_block_skip_scanner.sv @@
// conditional_block_skip_scanner
// Scans the source text of a false conditional block one byte per word and
// reports, for every byte, whether scanning goes on or a line-leading
// #else, #elif or #endif (or end of input) was found.
// Input channel req_: tdata carries the source byte, tlast marks end of
// input (the byte is then ignored). Result channel rsp_: tdata carries the
// 3-bit outcome code, one result word per input word.
// A word accepted on req_ is registered in the input stage, scanned by the
// core, and its outcome is registered in the output stage that drives rsp_.
// Throughput: one word per cycle while rsp_tready stays high; the scanner
// state is a single register set updated by one short transition per byte.
// After a nonzero outcome the scanner rearms to its reset state.
// Reset (synchronous, active high) empties both stages and returns the
// scanner to normal text at the start of a line.
// When rsp_tready is low the result holds, the input stage fills, and
// req_tready drops until the result word is taken; nothing is lost.
`default_nettype none

module conditional_block_skip_scanner #(
   parameter int WORD_MAX = 6
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] char_code
   input  wire        req_tlast,   // end_of_input
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] outcome, [7:3] zero
);
   import cbss_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        in_eof_ff;
   logic        out_valid_ff;
   outcome_type out_code_ff;
   outcome_type core_outcome;
   logic        out_free;
   logic        move;
   step_type    step;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      step.step = move;
      step.char_code = in_char_ff;
      step.end_of_input = in_eof_ff;
   end

   cbss_core #(
      .WORD_MAX (WORD_MAX)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_in (step),
      .outcome (core_outcome)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_eof_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_code_ff <= core_outcome;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_code_ff};

endmodule

`default_nettype wire

@@ bench/conditional_block_skip_scanner_tb.sv @@
`timescale 1ns / 1ps

module conditional_block_skip_scanner_tb;
   import cbss_pkg::*;

   localparam int SCAN_WORD_MAX = 6;
   localparam int RANDOM_BYTES = 790;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] char_code
   logic       req_tlast = 1'b0;   // end_of_input
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b1;
   logic [7:0] rsp_tdata;          // [2:0] outcome, [7:3] zero

   conditional_block_skip_scanner #(
      .WORD_MAX(SCAN_WORD_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // scanner state as predicted
   mode_type    scan_mode;
   logic        at_line_start;
   logic        slash_pending;
   logic [39:0] word_letters;
   logic [2:0]  word_count;

   outcome_type expected_outcomes[$];
   outcome_type wanted;
   int          mismatches = 0;
   int          results_seen = 0;
   int          bytes_sent = 0;
   int          directives_found = 0;
   int          eof_reports = 0;

   bit          pace_sender = 1'b0;
   bit          pace_receiver = 1'b0;
   int          burst_left = 0;
   logic [15:0] stall_pattern = 16'hffff;
   logic [5:0]  pattern_age = 6'd0;

   string spellings[10] = '{"else", "elif", "endif", "el", "elsewhere", "endiff", "eLSE",
                            "elifx", "ifdef", "e"};

   function automatic void rearm_scanner();
      scan_mode = MODE_NORMAL;
      at_line_start = 1'b1;
      slash_pending = 1'b0;
      word_letters = '0;
      word_count = '0;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic outcome_type plain_byte(logic [7:0] c, logic eof);
      if (eof) return OUT_EOF;
      case (c)
         CH_NEWLINE: begin
            at_line_start = 1'b1;
            slash_pending = 1'b0;
         end
         CH_HASH: begin
            if (at_line_start) scan_mode = MODE_HASH;
            at_line_start = 1'b0;
            slash_pending = 1'b0;
         end
         CH_SLASH: begin
            if (slash_pending) begin
               scan_mode = MODE_LINE_C;
               slash_pending = 1'b0;
            end else begin
               slash_pending = 1'b1;
            end
         end
         CH_STAR: begin
            if (slash_pending) begin
               scan_mode = MODE_BLOCK;
               slash_pending = 1'b0;
            end
         end
         CH_SPACE, CH_TAB: begin
            slash_pending = 1'b0;
         end
         CH_QUOTE: begin
            scan_mode = MODE_STRING;
         end
         default: begin
            slash_pending = 1'b0;
            at_line_start = 1'b0;
         end
      endcase
      return OUT_SKIP;
   endfunction

   function automatic outcome_type judge_word();
      if (word_count == 3'd3 && word_letters == {8'd0, WORD_LSE}) return OUT_ELSE;
      if (word_count == 3'd3 && word_letters == {8'd0, WORD_LIF}) return OUT_ELIF;
      if (word_count == 3'd4 && word_letters == {8'd0, WORD_NDIF}) return OUT_ENDIF;
      return OUT_SKIP;
   endfunction

   function automatic outcome_type scan_byte(logic [7:0] c, logic eof);
      outcome_type res;
      int          next_count;
      res = OUT_SKIP;
      case (scan_mode)
         MODE_HASH: begin
            scan_mode = MODE_NORMAL;
            if (!eof && c == CH_E) begin
               scan_mode = MODE_WORD;
               word_letters = '0;
               word_count = '0;
            end else begin
               res = plain_byte(c, eof);
            end
         end
         MODE_WORD: begin
            if (!eof && is_letter(c)) begin
               next_count = word_count + 1;
               if (next_count + 1 >= SCAN_WORD_MAX) begin
                  scan_mode = MODE_NORMAL;
                  word_letters = '0;
                  word_count = '0;
               end else begin
                  if (word_count < 3'd5) word_letters |= 40'(c) << (8 * word_count);
                  word_count = 3'(next_count);
               end
            end else begin
               res = judge_word();
               scan_mode = MODE_NORMAL;
               word_letters = '0;
               word_count = '0;
               if (res == OUT_SKIP) res = plain_byte(c, eof);
            end
         end
         MODE_LINE_C: begin
            if (eof) begin
               res = OUT_EOF;
            end else if (c == CH_NEWLINE) begin
               scan_mode = MODE_NORMAL;
               res = plain_byte(c, 1'b0);
            end
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (eof) begin
               res = OUT_EOF;
            end else if (c == CH_SLASH && scan_mode == MODE_BLOCK_STAR) begin
               scan_mode = MODE_NORMAL;
               slash_pending = 1'b0;
            end else begin
               scan_mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
         end
         MODE_STRING: begin
            if (eof) res = OUT_EOF_STR;
            else if (c == CH_QUOTE) scan_mode = MODE_STRING_Q;
         end
         MODE_STRING_Q: begin
            if (!eof && c == CH_QUOTE) begin
               scan_mode = MODE_STRING;
            end else begin
               scan_mode = MODE_NORMAL;
               res = plain_byte(c, eof);
            end
         end
         default: begin
            scan_mode = MODE_NORMAL;
            res = plain_byte(c, eof);
         end
      endcase
      if (res != OUT_SKIP) rearm_scanner();
      return res;
   endfunction

   // results are checked before the word accepted at the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         rearm_scanner();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            case (rsp_tdata[2:0])
               OUT_ELSE, OUT_ELIF, OUT_ENDIF: directives_found++;
               OUT_EOF, OUT_EOF_STR: eof_reports++;
               default: ;
            endcase
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               wanted = expected_outcomes.pop_front();
               if (rsp_tdata !== {5'd0, wanted}) begin
                  $display("%0t: outcome mismatch, expected %h, actual %h",
                           $time, {5'd0, wanted}, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) expected_outcomes.push_back(scan_byte(req_tdata, req_tlast));
      end
   end

   always @(posedge clock) begin
      stall_pattern <= (pattern_age == 6'd0) ? (16'($urandom) | 16'h8001)
                                             : {stall_pattern[0], stall_pattern[15:1]};
      pattern_age <= pattern_age + 6'd1;
      rsp_tready <= !pace_receiver || stall_pattern[0];
   end

   task automatic send_byte(input logic [7:0] c, input logic eof);
      req_tdata <= c;
      req_tlast <= eof;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (pace_sender) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_blanks();
      repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
   endtask

   task automatic send_filler(input int count, input logic [7:0] avoid);
      logic [7:0] c;
      repeat (count) begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h20, 8'h7e))
                                         : 8'($urandom_range("a", "z"));
         if (c == avoid) c = "x";
         send_byte(c, 1'b0);
      end
   endtask

   task automatic send_directive_line();
      send_blanks();
      if ($urandom_range(0, 3) == 0) begin
         send_text("/*");
         send_filler($urandom_range(0, 4), CH_STAR);
         send_text("*/");
         send_blanks();
      end
      send_byte(CH_HASH, 1'b0);
      send_text(spellings[$urandom_range(0, 9)]);
      case ($urandom_range(0, 6))
         0: send_byte(CH_SPACE, 1'b0);
         1: send_byte(CH_SLASH, 1'b0);
         2: send_byte(CH_QUOTE, 1'b0);
         3: send_byte(8'($urandom_range(0, 255)), 1'b0);
         4: send_end();
         default: send_byte(CH_NEWLINE, 1'b0);
      endcase
   endtask

   task automatic send_plain_line();
      send_blanks();
      send_filler($urandom_range(0, 10), CH_QUOTE);
      send_byte(CH_NEWLINE, 1'b0);
   endtask

   task automatic send_string_literal();
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 4)) begin
         send_filler($urandom_range(0, 3), CH_QUOTE);
         if ($urandom_range(0, 2) == 0) send_text("\"\"");
      end
      if ($urandom_range(0, 9) == 0) send_end();
      else send_byte(CH_QUOTE, 1'b0);
   endtask

   task automatic send_comment();
      if ($urandom_range(0, 1)) begin
         send_text("//");
         send_filler($urandom_range(0, 8), CH_NEWLINE);
         if ($urandom_range(0, 9) == 0) send_end();
         else send_byte(CH_NEWLINE, 1'b0);
      end else begin
         send_text("/*");
         repeat ($urandom_range(0, 6)) send_byte($urandom_range(0, 2) ? 8'($urandom_range(0, 255))
                                                                      : CH_STAR, 1'b0);
         if ($urandom_range(0, 9) == 0) send_end();
         else send_text("*/");
      end
   endtask

   task automatic test_directives();
      send_text(" \t#else ");
      send_text("#elif/");
      send_text("#endiff\n");
      send_text("#endif");
      send_end();
   endtask

   task automatic test_comments_and_strings();
      send_text("/**/#elif\n");
      send_text("/\"a\"\"\"/\n");
      send_byte(CH_QUOTE, 1'b0);
      send_end();
   endtask

   task automatic test_end_of_input();
      send_text("#x");
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_end();
      send_text("//");
      send_end();
      send_text("/*");
      send_end();
   endtask

   task automatic test_random_text();
      int goal;
      goal = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < goal) begin
         if ($urandom_range(0, 19) == 0) pace_sender = !pace_sender;
         if ($urandom_range(0, 19) == 0) pace_receiver = !pace_receiver;
         case ($urandom_range(0, 24))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: send_directive_line();
            10, 11, 12, 13, 14: send_plain_line();
            15, 16, 17: send_string_literal();
            18, 19, 20: send_comment();
            21, 22: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            default: send_end();
         endcase
      end
   endtask

   initial begin
      int drain_cycles;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directives();
      pace_sender = 1'b1;
      pace_receiver = 1'b1;
      test_comments_and_strings();
      test_end_of_input();
      test_random_text();
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (expected_outcomes.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_outcomes.size());
         mismatches += expected_outcomes.size();
      end
      $display("scanned %0d source bytes and checked %0d outcome words", bytes_sent, results_seen);
      $display("found %0d directives and %0d end-of-input reports", directives_found, eof_reports);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ conditional_block_skip_scanner.f @@
design/cbss_pkg.sv
design/cbss_core.sv
design/conditional_block_skip_scanner.sv
bench/conditional_block_skip_scanner_tb.sv
